// ===== sv/rcm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared constants, codes and types of the wire-density map unit.
// ----------------------------------------------------------------------------
package rcm_pkg;

    // grid and store geometry
    localparam int MAX_TILES_X = 64;
    localparam int MAX_TILES_Y = 64;
    localparam int RANGE_BINS  = 8;
    localparam int COORD_BITS  = 24;
    localparam int TX_W        = $clog2(MAX_TILES_X);
    localparam int TY_W        = $clog2(MAX_TILES_Y);
    localparam int BIN_W       = $clog2(RANGE_BINS);
    localparam int ADDR_W      = TX_W + TY_W;
    localparam int ROWS        = MAX_TILES_X * MAX_TILES_Y;
    localparam int WORD_W      = 32;

    // divider geometry
    localparam int DVD_W = 64;
    localparam int DEN_W = 2 * COORD_BITS;
    localparam int QUO_W = 32;
    localparam int DCNT_W = $clog2(DVD_W);

    // percent scale
    localparam logic [6:0] PCT_SCALE = 7'd100;

    // operations
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_RBIN  = 2'd2;
    localparam logic [1:0] OP_RTOT  = 2'd3;

    // result status
    localparam logic [2:0] STAT_DONE   = 3'd0;
    localparam logic [2:0] STAT_SUPPLY = 3'd1;
    localparam logic [2:0] STAT_ASPECT = 3'd2;
    localparam logic [2:0] STAT_DEGEN  = 3'd3;
    localparam logic [2:0] STAT_SAT    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_TILE_SIZE  = 3'd0;
    localparam logic [2:0] CFG_TILES_X    = 3'd1;
    localparam logic [2:0] CFG_TILES_Y    = 3'd2;
    localparam logic [2:0] CFG_EXTENT_X   = 3'd3;
    localparam logic [2:0] CFG_EXTENT_Y   = 3'd4;
    localparam logic [2:0] CFG_WIRE_WIDTH = 3'd5;
    localparam logic [2:0] CFG_ASP_LIMIT  = 3'd6;
    localparam logic [2:0] CFG_ASP_PINS   = 3'd7;

    // one tile row of the store: all bins of one tile
    typedef logic [RANGE_BINS-1:0][WORD_W-1:0] t_row;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUO_W-1:0]  quot;
        logic              ovf;
    } t_div_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_row              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== sv/rcm_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_divider
// Restoring divider, one quotient bit per cycle, 32-bit quotient with an overflow flag.
// ----------------------------------------------------------------------------
module rcm_divider import rcm_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DVD_W-1:0]  r_dvd;
    logic [QUO_W:0]    r_q;
    logic              r_ovf;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    // one trial subtraction
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DCNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_dvd <= i_req.dividend;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_ovf <= r_ovf | r_q[QUO_W];
            r_q   <= {r_q[QUO_W-1:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q[QUO_W-1:0];
    assign o_rsp.ovf  = r_ovf | r_q[QUO_W];

endmodule
`default_nettype wire

// ===== sv/rcm_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_store
// Density store: one row per tile holding all length bins, registered read.
// ----------------------------------------------------------------------------
module rcm_store import rcm_pkg::*; (
    input  wire      i_clk,
    input  t_mem_req i_req,
    output t_row     o_rdata
);

    t_row r_mem [ROWS];
    t_row r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/rudy_congestion_map_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rudy_congestion_map_unit
// Wire-density map over a tile grid with per-tile length bins.
// ----------------------------------------------------------------------------
// Items enter on the s-side stream (kind in tuser), one result per item
// leaves on the m-side stream (status in tuser, read value in tdata).
// Registers are written through the cfg channel, always ready.
// One item is worked at a time; the next one is taken once the result sits
// in the output register, so a stalled receiver only blocks after that.
// Reset clears the store with a pass over all tile rows, one tile row a cycle;
// no item is taken during it. A clear item runs the same pass and reports
// after it. A bin read returns one stored word; a tile total sums the bins
// one by one. An add item runs one divide for the congestion and four for
// the tile span, then one divide per overlapped tile on the bit-serial
// divider. Skipped nets answer without any divide.
// ----------------------------------------------------------------------------
module rudy_congestion_map_unit import rcm_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // items
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // xl[23:0] yl[47:24] xh[71:48] yh[95:72] pins[111:96] supply[112]
    // col[118:113] row[124:119] bin[127:125]
    input  wire [127:0] i_s_tdata,
    // operation[1:0]
    input  wire [1:0]   i_s_tuser,
    // results
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // density_value[31:0]
    output logic [31:0] o_m_tdata,
    // status[2:0]
    output logic [2:0]  o_m_tuser,
    // configuration
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [2:0]   i_cfg_index,
    input  wire [23:0]  i_cfg_data
);

    localparam int SP_W   = COORD_BITS + 2;
    localparam int ACC_W  = WORD_W + BIN_W;
    localparam int PROD_W = 64;

    // states
    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_FIN  = 5'd2;
    localparam logic [4:0] S_RD   = 5'd3;
    localparam logic [4:0] S_RDW  = 5'd4;
    localparam logic [4:0] S_SUM  = 5'd5;
    localparam logic [4:0] A_DIF  = 5'd6;
    localparam logic [4:0] A_ASP  = 5'd7;
    localparam logic [4:0] A_ACMP = 5'd8;
    localparam logic [4:0] A_AREA = 5'd9;
    localparam logic [4:0] A_CDIV = 5'd10;
    localparam logic [4:0] A_IDX  = 5'd11;
    localparam logic [4:0] A_IDXW = 5'd12;
    localparam logic [4:0] T_SPAN = 5'd13;
    localparam logic [4:0] T_OVL  = 5'd14;
    localparam logic [4:0] T_MUL1 = 5'd15;
    localparam logic [4:0] T_MUL2 = 5'd16;
    localparam logic [4:0] T_DIV  = 5'd17;
    localparam logic [4:0] T_M1   = 5'd18;
    localparam logic [4:0] T_M2   = 5'd19;
    localparam logic [4:0] T_WR   = 5'd20;
    localparam logic [4:0] T_NEXT = 5'd21;

    // configuration registers
    logic [15:0]           r_tile_size;
    logic [6:0]            r_tiles_x;
    logic [6:0]            r_tiles_y;
    logic [COORD_BITS-1:0] r_ext_x;
    logic [COORD_BITS-1:0] r_ext_y;
    logic [23:0]           r_wire_w;
    logic [15:0]           r_asp_lim;
    logic [15:0]           r_asp_pins;

    // control
    logic [4:0]            r_state;
    logic [ADDR_W-1:0]     r_ccnt;
    logic                  r_clr_item;
    logic                  r_ovalid;

    // item fields
    logic [1:0]            r_op;
    logic [COORD_BITS-1:0] r_xl, r_yl, r_xh, r_yh;
    logic [15:0]           r_pins;
    logic [TX_W-1:0]       r_col;
    logic [TY_W-1:0]       r_row;
    logic [BIN_W-1:0]      r_bsel;

    // work registers
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [COORD_BITS:0]   r_hpwl;
    logic [PROD_W-1:0]     r_prod;
    logic [WORD_W-1:0]     r_cong;
    logic                  r_sat;
    logic [BIN_W-1:0]      r_bin;
    logic [1:0]            r_k;
    logic [TX_W-1:0]       r_x0, r_x1, r_cx;
    logic [TY_W-1:0]       r_y0, r_y1, r_cy;
    logic [SP_W-1:0]       r_tlx, r_thx, r_tly, r_thy;
    logic [COORD_BITS-1:0] r_ix, r_iy, r_tw, r_th;
    logic [16:0]           r_ratio;
    logic [ACC_W-1:0]      r_acc;
    logic [BIN_W-1:0]      r_bcnt;
    logic [2:0]            r_stat;
    logic [WORD_W-1:0]     r_val;
    logic [2:0]            r_ostat;
    logic [WORD_W-1:0]     r_oval;

    // submodule links
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_mem_req w_mem_req;
    t_row     w_rdata;

    // derived values
    logic [15:0]           w_ts;
    logic [6:0]            w_nx, w_ny, w_nxm1, w_nym1;
    logic                  w_s_acc;
    logic                  w_rd_ok;
    logic signed [COORD_BITS:0] w_dx, w_dy;
    logic [COORD_BITS-1:0] w_mx, w_mn;
    logic [BIN_W-1:0]      w_bin;
    logic [39:0]           w_mul_asp;
    logic [COORD_BITS+24:0] w_mul_num;
    logic [DEN_W-1:0]      w_mul_area, w_mul_ovl, w_mul_tarea;
    logic [48:0]           w_mul_cr;
    logic [55:0]           w_mul_pct;
    logic [TX_W-1:0]       w_qx;
    logic [TY_W-1:0]       w_qy;
    logic [SP_W-1:0]       w_tlx, w_thx, w_tly, w_thy;
    logic [SP_W-1:0]       w_hx, w_lx, w_hy, w_ly;
    logic signed [SP_W-1:0] w_ix, w_iy;
    logic [SP_W-1:0]       w_tw, w_th;
    logic [39:0]           w_amt;
    logic                  w_amt_sat;
    logic [WORD_W-1:0]     w_amt32;
    logic [WORD_W:0]       w_sum;
    logic [WORD_W-1:0]     w_new;
    t_row                  w_wrow;
    logic [ACC_W-1:0]      w_acc_n;
    logic                  w_last_tile;

    rcm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    rcm_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    // register values as used
    assign w_ts   = (r_tile_size == 16'd0) ? 16'd1 : r_tile_size;
    assign w_nx   = (r_tiles_x == 7'd0) ? 7'd1 :
                    (r_tiles_x > 7'(MAX_TILES_X)) ? 7'(MAX_TILES_X) : r_tiles_x;
    assign w_ny   = (r_tiles_y == 7'd0) ? 7'd1 :
                    (r_tiles_y > 7'(MAX_TILES_Y)) ? 7'(MAX_TILES_Y) : r_tiles_y;
    assign w_nxm1 = w_nx - 7'd1;
    assign w_nym1 = w_ny - 7'd1;

    // handshakes
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_oval;
    assign o_m_tuser   = r_ostat;

    // read range check
    assign w_rd_ok = (7'(r_col) < w_nx) && (7'(r_row) < w_ny) &&
                     (32'(r_bsel) < RANGE_BINS);

    // box extents
    assign w_dx = $signed({1'b0, r_xh}) - $signed({1'b0, r_xl});
    assign w_dy = $signed({1'b0, r_yh}) - $signed({1'b0, r_yl});
    assign w_mx = (r_dx > r_dy) ? r_dx : r_dy;
    assign w_mn = (r_dx > r_dy) ? r_dy : r_dx;

    // length bin: last doubling of twice the tile size that still fits
    always_comb begin
        w_bin = '0;
        for (int k = 1; k < RANGE_BINS; k++) begin
            if ((33'(w_ts) << (k + 1)) <= 33'(r_hpwl)) begin
                w_bin = BIN_W'(k);
            end
        end
    end

    // multipliers, each feeding a register
    assign w_mul_asp   = r_asp_lim * w_mn;
    assign w_mul_num   = r_hpwl * r_wire_w;
    assign w_mul_area  = r_dx * r_dy;
    assign w_mul_ovl   = r_ix * r_iy;
    assign w_mul_tarea = r_tw * r_th;
    assign w_mul_cr    = r_cong * r_ratio;
    assign w_mul_pct   = r_prod[48:0] * PCT_SCALE;

    // tile index clamp
    assign w_qx = (w_div_rsp.quot > 32'(w_nxm1)) ? w_nxm1[TX_W-1:0]
                                                 : w_div_rsp.quot[TX_W-1:0];
    assign w_qy = (w_div_rsp.quot > 32'(w_nym1)) ? w_nym1[TY_W-1:0]
                                                 : w_div_rsp.quot[TY_W-1:0];

    // tile span; last tile in use stretches to the die edge
    assign w_tlx = SP_W'(r_cx) * SP_W'(w_ts);
    assign w_tly = SP_W'(r_cy) * SP_W'(w_ts);
    assign w_thx = (7'(r_cx) == w_nxm1) ? SP_W'(r_ext_x) : w_tlx + SP_W'(w_ts);
    assign w_thy = (7'(r_cy) == w_nym1) ? SP_W'(r_ext_y) : w_tly + SP_W'(w_ts);

    // overlap of box and tile
    assign w_hx = (SP_W'(r_xh) < r_thx) ? SP_W'(r_xh) : r_thx;
    assign w_lx = (SP_W'(r_xl) > r_tlx) ? SP_W'(r_xl) : r_tlx;
    assign w_hy = (SP_W'(r_yh) < r_thy) ? SP_W'(r_yh) : r_thy;
    assign w_ly = (SP_W'(r_yl) > r_tly) ? SP_W'(r_yl) : r_tly;
    assign w_ix = $signed(w_hx) - $signed(w_lx);
    assign w_iy = $signed(w_hy) - $signed(w_ly);
    assign w_tw = r_thx - r_tlx;
    assign w_th = r_thy - r_tly;

    // bin update with saturation
    assign w_amt     = r_prod[55:16];
    assign w_amt_sat = |w_amt[39:32];
    assign w_amt32   = w_amt_sat ? '1 : w_amt[31:0];
    assign w_sum     = {1'b0, w_rdata[r_bin]} + {1'b0, w_amt32};
    assign w_new     = w_sum[WORD_W] ? '1 : w_sum[WORD_W-1:0];
    always_comb begin
        w_wrow        = w_rdata;
        w_wrow[r_bin] = w_new;
    end

    // tile total accumulation
    assign w_acc_n = r_acc + ACC_W'(w_rdata[r_bcnt]);

    assign w_last_tile = (r_cx == r_x1) && (r_cy == r_y1);

    // divider requests
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = '0;
        w_div_req.divisor  = '0;
        unique case (r_state)
            A_AREA: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = DVD_W'({r_prod[48:0], 8'd0});
                w_div_req.divisor  = w_mul_area;
            end
            A_IDX: begin
                w_div_req.start   = 1'b1;
                w_div_req.divisor = DEN_W'(w_ts);
                unique case (r_k)
                    2'd0:    w_div_req.dividend = DVD_W'(r_xl);
                    2'd1:    w_div_req.dividend = DVD_W'(r_xh);
                    2'd2:    w_div_req.dividend = DVD_W'(r_yl);
                    default: w_div_req.dividend = DVD_W'(r_yh);
                endcase
            end
            T_MUL2: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {r_prod[47:0], 16'd0};
                w_div_req.divisor  = w_mul_tarea;
            end
            default: begin
            end
        endcase
    end

    // store requests
    always_comb begin
        w_mem_req.we    = 1'b0;
        w_mem_req.waddr = {r_cy, r_cx};
        w_mem_req.wdata = w_wrow;
        w_mem_req.re    = 1'b0;
        w_mem_req.raddr = {r_cy, r_cx};
        unique case (r_state)
            S_CLR: begin
                w_mem_req.we    = 1'b1;
                w_mem_req.waddr = r_ccnt;
                w_mem_req.wdata = '0;
            end
            S_RD: begin
                w_mem_req.re    = w_rd_ok;
                w_mem_req.raddr = {r_row, r_col};
            end
            T_MUL2: w_mem_req.re = 1'b1;
            T_WR:   w_mem_req.we = 1'b1;
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_size <= 16'd1;
            r_tiles_x   <= 7'd64;
            r_tiles_y   <= 7'd64;
            r_ext_x     <= '1;
            r_ext_y     <= '1;
            r_wire_w    <= 24'd256;
            r_asp_lim   <= '0;
            r_asp_pins  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TILE_SIZE:  r_tile_size <= i_cfg_data[15:0];
                CFG_TILES_X:    r_tiles_x   <= i_cfg_data[6:0];
                CFG_TILES_Y:    r_tiles_y   <= i_cfg_data[6:0];
                CFG_EXTENT_X:   r_ext_x     <= i_cfg_data[COORD_BITS-1:0];
                CFG_EXTENT_Y:   r_ext_y     <= i_cfg_data[COORD_BITS-1:0];
                CFG_WIRE_WIDTH: r_wire_w    <= i_cfg_data;
                CFG_ASP_LIMIT:  r_asp_lim   <= i_cfg_data[15:0];
                CFG_ASP_PINS:   r_asp_pins  <= i_cfg_data[15:0];
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_FIN && (!r_ovalid || i_m_tready)) begin
            r_ovalid <= 1'b1;
            r_ostat  <= r_stat;
            r_oval   <= r_val;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_ccnt     <= '0;
            r_clr_item <= 1'b0;
        end else begin
            unique case (r_state)
                // clearing pass, one tile row a cycle
                S_CLR: begin
                    r_ccnt <= r_ccnt + 1'b1;
                    if (r_ccnt == ADDR_W'(ROWS - 1)) begin
                        r_state <= r_clr_item ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_op   <= i_s_tuser;
                        r_xl   <= i_s_tdata[23:0];
                        r_yl   <= i_s_tdata[47:24];
                        r_xh   <= i_s_tdata[71:48];
                        r_yh   <= i_s_tdata[95:72];
                        r_pins <= i_s_tdata[111:96];
                        r_col  <= i_s_tdata[118:113];
                        r_row  <= i_s_tdata[124:119];
                        r_bsel <= i_s_tdata[127:125];
                        r_stat <= STAT_DONE;
                        r_val  <= '0;
                        r_sat  <= 1'b0;
                        unique case (i_s_tuser)
                            OP_CLEAR: begin
                                r_ccnt     <= '0;
                                r_clr_item <= 1'b1;
                                r_state    <= S_CLR;
                            end
                            OP_ADD: begin
                                if (i_s_tdata[112]) begin
                                    r_stat  <= STAT_SUPPLY;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= A_DIF;
                                end
                            end
                            OP_RBIN, OP_RTOT: r_state <= S_RD;
                        endcase
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                // reads
                S_RD: begin
                    r_state <= w_rd_ok ? S_RDW : S_FIN;
                end
                S_RDW: begin
                    r_acc  <= '0;
                    r_bcnt <= '0;
                    if (r_op == OP_RBIN) begin
                        r_val   <= w_rdata[r_bsel];
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_acc  <= w_acc_n;
                    r_bcnt <= r_bcnt + 1'b1;
                    if (r_bcnt == BIN_W'(RANGE_BINS - 1)) begin
                        if (|w_acc_n[ACC_W-1:WORD_W]) begin
                            r_val  <= '1;
                            r_stat <= STAT_SAT;
                        end else begin
                            r_val <= w_acc_n[WORD_W-1:0];
                        end
                        r_state <= S_FIN;
                    end
                end
                // net setup
                A_DIF: begin
                    if (w_dx <= 0 || w_dy <= 0) begin
                        r_stat  <= STAT_DEGEN;
                        r_state <= S_FIN;
                    end else begin
                        r_dx    <= w_dx[COORD_BITS-1:0];
                        r_dy    <= w_dy[COORD_BITS-1:0];
                        r_hpwl  <= COORD_BITS'(w_dx[COORD_BITS-1:0])
                                   + (COORD_BITS+1)'(w_dy[COORD_BITS-1:0]);
                        r_state <= A_ASP;
                    end
                end
                A_ASP: begin
                    r_prod  <= PROD_W'(w_mul_asp);
                    r_bin   <= w_bin;
                    r_state <= A_ACMP;
                end
                A_ACMP: begin
                    if (r_asp_lim != 16'd0 && r_pins <= r_asp_pins &&
                        {8'd0, w_mx, 8'd0} > r_prod[39:0]) begin
                        r_stat  <= STAT_ASPECT;
                        r_state <= S_FIN;
                    end else begin
                        r_prod  <= PROD_W'(w_mul_num);
                        r_state <= A_AREA;
                    end
                end
                A_AREA: begin
                    r_state <= A_CDIV;
                end
                A_CDIV: begin
                    if (w_div_rsp.done) begin
                        r_cong  <= w_div_rsp.ovf ? '1 : w_div_rsp.quot;
                        r_sat   <= w_div_rsp.ovf;
                        r_k     <= 2'd0;
                        r_state <= A_IDX;
                    end
                end
                A_IDX: begin
                    r_state <= A_IDXW;
                end
                A_IDXW: begin
                    if (w_div_rsp.done) begin
                        unique case (r_k)
                            2'd0: r_x0 <= w_qx;
                            2'd1: r_x1 <= w_qx;
                            2'd2: r_y0 <= w_qy;
                            2'd3: r_y1 <= w_qy;
                        endcase
                        r_k <= r_k + 1'b1;
                        if (r_k == 2'd3) begin
                            r_cx    <= r_x0;
                            r_cy    <= r_y0;
                            r_state <= T_SPAN;
                        end else begin
                            r_state <= A_IDX;
                        end
                    end
                end
                // per tile read, modify, write
                T_SPAN: begin
                    r_tlx   <= w_tlx;
                    r_thx   <= w_thx;
                    r_tly   <= w_tly;
                    r_thy   <= w_thy;
                    r_state <= T_OVL;
                end
                T_OVL: begin
                    if (r_thx <= r_tlx || r_thy <= r_tly || w_ix <= 0 || w_iy <= 0) begin
                        r_state <= T_NEXT;
                    end else begin
                        r_ix    <= w_ix[COORD_BITS-1:0];
                        r_iy    <= w_iy[COORD_BITS-1:0];
                        r_tw    <= w_tw[COORD_BITS-1:0];
                        r_th    <= w_th[COORD_BITS-1:0];
                        r_state <= T_MUL1;
                    end
                end
                T_MUL1: begin
                    r_prod  <= PROD_W'(w_mul_ovl);
                    r_state <= T_MUL2;
                end
                T_MUL2: begin
                    r_state <= T_DIV;
                end
                T_DIV: begin
                    if (w_div_rsp.done) begin
                        r_ratio <= w_div_rsp.quot[16:0];
                        r_state <= T_M1;
                    end
                end
                T_M1: begin
                    r_prod  <= PROD_W'(w_mul_cr);
                    r_state <= T_M2;
                end
                T_M2: begin
                    r_prod  <= PROD_W'(w_mul_pct);
                    r_state <= T_WR;
                end
                T_WR: begin
                    r_sat   <= r_sat | w_amt_sat | w_sum[WORD_W];
                    r_state <= T_NEXT;
                end
                T_NEXT: begin
                    if (w_last_tile) begin
                        r_stat  <= r_sat ? STAT_SAT : STAT_DONE;
                        r_state <= S_FIN;
                    end else begin
                        if (r_cy == r_y1) begin
                            r_cy <= r_y0;
                            r_cx <= r_cx + 1'b1;
                        end else begin
                            r_cy <= r_cy + 1'b1;
                        end
                        r_state <= T_SPAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // the divider is never restarted while it still works
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    // an accepted item closes the input until its result is formed
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !o_s_tready)
        else $error("second item taken while one is in work");

    // a tile update stays inside the net's clamped tile window
    a_tile_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_WR) |-> (r_cx >= r_x0 && r_cx <= r_x1 &&
                               r_cy >= r_y0 && r_cy <= r_y1))
        else $error("tile update outside the net window");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_rudy_congestion_map_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rudy_congestion_map_unit
// Self-checking bench for the tile wire-density map unit.
// ----------------------------------------------------------------------------
// Items go in on the s-side stream and every result is checked against a
// bit-accurate density map kept inside the bench. Directed tests cover the
// skip rules, clamped and stretched edge tiles, saturation and out-of-range
// reads; a long receiver stall and random phases under changing grid settings
// follow, with bursts of idle cycles on both sides and a sender pause.
// ----------------------------------------------------------------------------
module tb_rudy_congestion_map_unit;
    import rcm_pkg::*;

    localparam int  WATCHDOG_LIMIT = 50000;
    localparam longint WORD_MAX    = 64'h0000_0000_FFFF_FFFF;

    // dut signals
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = OP_CLEAR;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = CFG_TILE_SIZE;
    logic [23:0]  cfg_data = '0;

    rudy_congestion_map_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct {
        logic [2:0]  status;
        logic [31:0] density;
    } t_map_result;

    // bench copy of the map and its registers
    logic [31:0] map_store [0:MAX_TILES_X*MAX_TILES_Y*RANGE_BINS-1];
    logic [15:0] g_tile;
    logic [6:0]  g_tx, g_ty;
    logic [23:0] g_ex, g_ey, g_ww;
    logic [15:0] g_asp, g_asp_pins;

    t_map_result density_q [$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  adds_sent = 0;
    int  cfg_writes = 0;
    bit  idle_en = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    logic [5:0] last_col = '0, last_row = '0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint frac_div(input longint num, input longint den,
                                        input int sh, inout bit sat);
        longint ip, r, v;
        int i;
        ip = num / den;
        r  = num % den;
        if (ip > (WORD_MAX >> sh)) begin
            sat = 1'b1;
            return WORD_MAX;
        end
        v = ip;
        for (i = 0; i < sh; i++) begin
            r = r << 1;
            v = v << 1;
            if (r >= den) begin
                r = r - den;
                v = v | 64'd1;
            end
        end
        return v;
    endfunction

    function automatic longint tiles_in_use(input logic [6:0] v, input int lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic int map_addr(input longint col, input longint row,
                                    input longint b);
        return int'((row * MAX_TILES_X + col) * RANGE_BINS + b);
    endfunction

    function automatic logic [2:0] spread_net(input logic [23:0] bxl, byl, bxh, byh,
                                              input logic [15:0] pins,
                                              input logic sup);
        longint xl, yl, xh, yh, ts, nx, ny, dx, dy, mx, mn, hpwl, cong;
        longint x0, x1, y0, y1, cx, cy, tlx, thx, tly, thy, ix, iy;
        longint ratio, amt, sum, b;
        int k;
        bit sat;
        sat = 1'b0;
        xl = bxl; yl = byl; xh = bxh; yh = byh;
        ts = (g_tile == 0) ? 1 : g_tile;
        nx = tiles_in_use(g_tx, MAX_TILES_X);
        ny = tiles_in_use(g_ty, MAX_TILES_Y);
        if (sup) return STAT_SUPPLY;
        dx = xh - xl;
        dy = yh - yl;
        if (dx <= 0 || dy <= 0) return STAT_DEGEN;
        if (g_asp != 0 && pins <= g_asp_pins) begin
            mx = (dx > dy) ? dx : dy;
            mn = (dx > dy) ? dy : dx;
            if (mx * 256 > longint'(g_asp) * mn) return STAT_ASPECT;
        end
        hpwl = dx + dy;
        cong = frac_div(hpwl * longint'(g_ww), dx * dy, 8, sat);
        b = 0;
        while (b + 1 < RANGE_BINS && (((ts * 2) << (b + 1)) <= hpwl)) b++;
        x0 = xl / ts; if (x0 > nx - 1) x0 = nx - 1;
        x1 = xh / ts; if (x1 > nx - 1) x1 = nx - 1;
        y0 = yl / ts; if (y0 > ny - 1) y0 = ny - 1;
        y1 = yh / ts; if (y1 > ny - 1) y1 = ny - 1;
        for (cx = x0; cx <= x1; cx++) begin
            for (cy = y0; cy <= y1; cy++) begin
                tlx = cx * ts;
                thx = (cx == nx - 1) ? longint'(g_ex) : tlx + ts;
                tly = cy * ts;
                thy = (cy == ny - 1) ? longint'(g_ey) : tly + ts;
                // a squeezed edge tile takes nothing
                if (thx > tlx && thy > tly) begin
                    ix = ((xh < thx) ? xh : thx) - ((xl > tlx) ? xl : tlx);
                    iy = ((yh < thy) ? yh : thy) - ((yl > tly) ? yl : tly);
                    if (ix > 0 && iy > 0) begin
                        ratio = frac_div(ix * iy, (thx - tlx) * (thy - tly), 16, sat);
                        amt = (cong * ratio * 100) >> 16;
                        if (amt > WORD_MAX) begin
                            amt = WORD_MAX;
                            sat = 1'b1;
                        end
                        k = map_addr(cx, cy, b);
                        sum = longint'(map_store[k]) + amt;
                        if (sum > WORD_MAX) begin
                            sum = WORD_MAX;
                            sat = 1'b1;
                        end
                        map_store[k] = sum[31:0];
                    end
                end
            end
        end
        return sat ? STAT_SAT : STAT_DONE;
    endfunction

    function automatic void wipe_map();
        foreach (map_store[i]) map_store[i] = '0;
    endfunction

    function automatic t_map_result predict_item(input logic [1:0] op,
                                                 input logic [23:0] xl, yl, xh, yh,
                                                 input logic [15:0] pins,
                                                 input logic sup,
                                                 input logic [5:0] col, row,
                                                 input logic [2:0] bsel);
        t_map_result res;
        longint sum;
        bit in_grid;
        int b;
        res.status  = STAT_DONE;
        res.density = '0;
        in_grid = (col < tiles_in_use(g_tx, MAX_TILES_X)) &&
                  (row < tiles_in_use(g_ty, MAX_TILES_Y));
        case (op)
            OP_CLEAR: wipe_map();
            OP_ADD:   res.status = spread_net(xl, yl, xh, yh, pins, sup);
            OP_RBIN: begin
                if (in_grid && bsel < RANGE_BINS)
                    res.density = map_store[map_addr(col, row, bsel)];
            end
            default: begin
                if (in_grid) begin
                    sum = 0;
                    for (b = 0; b < RANGE_BINS; b++)
                        sum += map_store[map_addr(col, row, b)];
                    if (sum > WORD_MAX) begin
                        sum = WORD_MAX;
                        res.status = STAT_SAT;
                    end
                    res.density = sum[31:0];
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [23:0] xl, yl, xh, yh,
                             input logic [15:0] pins, input logic sup,
                             input logic [5:0] col, row, input logic [2:0] bsel);
        bit hs;
        density_q.push_back(predict_item(op, xl, yl, xh, yh, pins, sup, col, row, bsel));
        items_sent++;
        if (op == OP_ADD) adds_sent++;
        // random idle burst ahead of this transfer
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bsel, row, col, sup, pins, yh, xh, yl, xl};
        do begin
            @(negedge i_clk);
            hs = s_tready;
            @(posedge i_clk);
        end while (!hs);
    endtask

    task automatic add_box(input logic [23:0] xl, yl, xh, yh, input logic [15:0] pins,
                           input logic sup);
        send_item(OP_ADD, xl, yl, xh, yh, pins, sup, '0, '0, '0);
    endtask

    task automatic read_bin(input logic [5:0] col, row, input logic [2:0] bsel);
        send_item(OP_RBIN, '0, '0, '0, '0, '0, 1'b0, col, row, bsel);
    endtask

    task automatic read_total(input logic [5:0] col, row);
        send_item(OP_RTOT, '0, '0, '0, '0, '0, 1'b0, col, row, '0);
    endtask

    task automatic clear_map();
        send_item(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0);
    endtask

    // sender pause until every expected result is back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (density_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] value);
        bit hs;
        case (idx)
            CFG_TILE_SIZE:  g_tile     = value[15:0];
            CFG_TILES_X:    g_tx       = value[6:0];
            CFG_TILES_Y:    g_ty       = value[6:0];
            CFG_EXTENT_X:   g_ex       = value;
            CFG_EXTENT_Y:   g_ey       = value;
            CFG_WIRE_WIDTH: g_ww       = value;
            CFG_ASP_LIMIT:  g_asp      = value[15:0];
            default:        g_asp_pins = value[15:0];
        endcase
        cfg_writes++;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(negedge i_clk);
            hs = cfg_ready;
            @(posedge i_clk);
        end while (!hs);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [23:0] ts, nx, ny, ex, ey);
        wait_results();
        cfg_write(CFG_TILE_SIZE, ts);
        cfg_write(CFG_TILES_X, nx);
        cfg_write(CFG_TILES_Y, ny);
        cfg_write(CFG_EXTENT_X, ex);
        cfg_write(CFG_EXTENT_Y, ey);
    endtask

    task automatic set_net_rules(input logic [23:0] ww, asp, asp_pins);
        wait_results();
        cfg_write(CFG_WIRE_WIDTH, ww);
        cfg_write(CFG_ASP_LIMIT, asp);
        cfg_write(CFG_ASP_PINS, asp_pins);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls and the long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result check, sampled mid-cycle ahead of the transfer edge
    always @(negedge i_clk) begin
        t_map_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (density_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d value=%h",
                             m_tuser, m_tdata);
            end else begin
                want = density_q.pop_front();
                if (m_tuser !== want.status || m_tdata !== want.density) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp status=%0d value=%h got status=%0d value=%h",
                                 results_seen, want.status, want.density, m_tuser, m_tdata);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("ERROR: watchdog expired, %0d results outstanding", density_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        read_total(6'd0, 6'd0);
        read_bin(6'd63, 6'd63, 3'd7);
        add_box(24'd10, 24'd10, 24'd13, 24'd12, 16'd2, 1'b0);
        read_bin(6'd10, 6'd10, 3'd0);
        read_total(6'd12, 6'd11);
        clear_map();
        read_total(6'd10, 6'd10);
    endtask

    task automatic test_skip_and_edges();
        // 8x8 grid, last column stretched, last row squeezed to nothing
        set_grid(24'd1000, 24'd8, 24'd8, 24'd9500, 24'd6500);
        set_net_rules(24'd256, 24'd512, 24'd4);
        add_box(24'd100, 24'd100, 24'd900, 24'd900, 16'd3, 1'b1);   // supply
        add_box(24'd900, 24'd100, 24'd100, 24'd900, 16'd3, 1'b0);   // inverted
        add_box(24'd100, 24'd500, 24'd900, 24'd500, 16'd3, 1'b0);   // zero area
        add_box(24'd0, 24'd0, 24'd3000, 24'd100, 16'd2, 1'b0);      // flat, few pins
        add_box(24'd0, 24'd0, 24'd3000, 24'd100, 16'd5, 1'b0);      // flat, many pins
        add_box(24'd1500, 24'd1200, 24'd2600, 24'd2900, 16'd0, 1'b0);
        add_box(24'd7000, 24'd6000, 24'd9400, 24'd7400, 16'd3, 1'b0);
        add_box(24'd12000, 24'd12000, 24'd12500, 24'd12400, 16'hFFFF, 1'b0);
        read_bin(6'd1, 6'd0, 3'd1);
        read_total(6'd7, 6'd6);
        read_total(6'd7, 6'd7);
        read_total(6'd2, 6'd2);
        read_total(6'd10, 6'd1);     // beyond columns in use
        read_bin(6'd1, 6'd9, 3'd0);  // beyond rows in use
        // saturation of congestion, of one bin and of a tile total
        set_net_rules(24'hFFFFFF, 24'd0, 24'd0);
        add_box(24'd0, 24'd0, 24'd1, 24'd1, 16'd2, 1'b0);
        repeat (5) add_box(24'd0, 24'd0, 24'd1000, 24'd1000, 16'd2, 1'b0);
        add_box(24'd0, 24'd0, 24'd1000, 24'd3000, 16'd2, 1'b0);
        read_bin(6'd0, 6'd0, 3'd0);
        read_total(6'd0, 6'd0);
        clear_map();
        read_total(6'd0, 6'd0);
    endtask

    task automatic test_register_extremes();
        // widest tiles, zero wire width, widest aspect filter
        set_grid(24'd65535, 24'd64, 24'd64, 24'hFFFFFF, 24'hFFFFFF);
        set_net_rules(24'd0, 24'hFFFF, 24'hFFFF);
        add_box(24'd60000, 24'd60000, 24'd70000, 24'd70000, 16'hFFFF, 1'b0);
        add_box(24'hFFFF00, 24'hFFFF00, 24'hFFFFFF, 24'hFFFFFF, 16'd1, 1'b0);
        read_total(6'd0, 6'd0);
        read_total(6'd63, 6'd63);
        set_net_rules(24'hFFFFFF, 24'd0, 24'd0);
        add_box(24'd60000, 24'd60000, 24'd70000, 24'd70000, 16'hFFFF, 1'b0);
        read_bin(6'd1, 6'd1, 3'd0);
        // zero tile size and counts out of range
        set_grid(24'd0, 24'd0, 24'd127, 24'd5, 24'd70);
        set_net_rules(24'd300, 24'd256, 24'd10);
        add_box(24'd0, 24'd0, 24'd2, 24'd2, 16'd2, 1'b0);
        add_box(24'd1, 24'd60, 24'd4, 24'd63, 16'd20, 1'b0);
        add_box(24'd3, 24'd5, 24'd9, 24'd7, 16'd20, 1'b0);
        read_total(6'd0, 6'd61);
        read_total(6'd1, 6'd0);
        // single tile spanning the whole die
        set_grid(24'd1000, 24'd1, 24'd1, 24'hFFFFFF, 24'hFFFFFF);
        set_net_rules(24'd256, 24'd0, 24'd0);
        add_box(24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 1'b0);
        add_box(24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 16'hFFFF, 1'b1);
        read_bin(6'd0, 6'd0, 3'd7);
        read_total(6'd0, 6'd0);
        clear_map();
    endtask

    task automatic test_output_stall();
        set_grid(24'd500, 24'd16, 24'd16, 24'd8000, 24'd8000);
        wait_results();
        @(negedge i_clk);
        hold_left = 400;
        @(posedge i_clk);
        add_box(24'd100, 24'd100, 24'd700, 24'd400, 16'd4, 1'b0);
        repeat (6) read_bin(6'd0, 6'd0, 3'd0);
        repeat (4) read_total(6'd1, 6'd0);
        wait_results();
    endtask

    task automatic test_random_traffic();
        int phase, n, sel, ts, nx, ny;
        logic [23:0] xl, yl, xh, yh, t;
        logic sup;
        for (phase = 0; phase < 4; phase++) begin
            ts = $urandom_range(200, 4000);
            nx = $urandom_range(1, 64);
            ny = $urandom_range(1, 64);
            set_grid(ts, nx, ny, nx * ts - ts / 2 + $urandom_range(0, ts),
                     ny * ts - ts / 2 + $urandom_range(0, ts));
            set_net_rules(($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                      : $urandom_range(64, 1024),
                          ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(256, 2048),
                          $urandom_range(0, 16'hFFFF));
            // the last phase runs with no idling at all
            idle_en = (phase != 3);
            for (n = 0; n < 130; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    xl = $urandom_range(0, nx * ts + ts);
                    yl = $urandom_range(0, ny * ts + ts);
                    xh = xl + $urandom_range(1, ts * 3 / 2);
                    yh = yl + $urandom_range(1, ts * 3 / 2);
                    last_col = (xl / ts > 63) ? 6'd63 : 6'(xl / ts);
                    last_row = (yl / ts > 63) ? 6'd63 : 6'(yl / ts);
                    add_box(xl, yl, xh, yh, $urandom_range(0, 16'hFFFF),
                            ($urandom_range(0, 19) == 0));
                end else if (sel < 65) begin
                    // noise: supply or inverted nets with arbitrary coordinates
                    xl = $urandom; yl = $urandom; xh = $urandom; yh = $urandom;
                    sup = $urandom_range(0, 1);
                    if (!sup && xh > xl) begin
                        t = xl; xl = xh; xh = t;
                    end
                    add_box(xl, yl, xh, yh, $urandom, sup);
                end else if (sel < 80) begin
                    if ($urandom_range(0, 2) != 0) read_bin(last_col, last_row, $urandom);
                    else read_bin($urandom, $urandom, $urandom);
                end else if (sel < 99) begin
                    if ($urandom_range(0, 2) != 0) read_total(last_col, last_row);
                    else read_total($urandom, $urandom);
                end else begin
                    clear_map();
                end
                if (phase == 1 && n == 60) wait_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        wipe_map();
        g_tile = 16'd1; g_tx = 7'd64; g_ty = 7'd64;
        g_ex = 24'hFFFFFF; g_ey = 24'hFFFFFF; g_ww = 24'd256;
        g_asp = '0; g_asp_pins = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        idle_en = 1'b1;
        test_skip_and_edges();
        test_register_extremes();
        test_output_stall();
        test_random_traffic();

        wait_results();
        repeat (50) @(posedge i_clk);
        $display("Summary: %0d items (%0d net adds), %0d results, %0d register writes",
                 items_sent, adds_sent, results_seen, cfg_writes);
        $display("Covered skip rules, edge tiles, saturation, stalls and random grids");
        if (mismatches == 0 && density_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("ERROR: %0d mismatches, %0d results missing", mismatches,
                     density_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rcm_pkg.sv
sv/rcm_divider.sv
sv/rcm_store.sv
sv/rudy_congestion_map_unit.sv
tb/sv/tb_rudy_congestion_map_unit.sv
